// File: rtl/bca_pkg.sv
`default_nettype none

package bca_pkg;

    // bitmap geometry
    localparam int BITMAP_BYTES   = 2048;
    localparam int WORD_W         = 64;
    localparam int BIT_W          = 6;
    localparam int TOTAL_CLUSTERS = BITMAP_BYTES * 8;
    localparam int MAP_WORDS      = (TOTAL_CLUSTERS + WORD_W - 1) / WORD_W;
    localparam int FIELD_LIMIT    = 16384;
    localparam int CLAMP          = (TOTAL_CLUSTERS < FIELD_LIMIT) ? TOTAL_CLUSTERS
                                                                   : FIELD_LIMIT;
    localparam int ADDR_W         = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int CNT_W          = $clog2(MAP_WORDS + 1);

    // field widths
    localparam int OP_W        = 2;
    localparam int CLUSTER_W   = 14;
    localparam int COUNT_W     = 15;
    localparam int ST_W        = 2;
    localparam int COUNT_RESET = 16384;

    typedef enum logic [OP_W-1:0] {
        OP_QUERY = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_MARK  = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR  = 3'd0,
        S_IDLE   = 3'd1,
        S_READ   = 3'd2,
        S_UPD    = 3'd3,
        S_SCAN   = 3'd4,
        S_COMMIT = 3'd5,
        S_DONE   = 3'd6
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clr;
        logic accept;
        logic scan;
        logic upd;
        logic commit;
        logic res_range;
        logic res_full;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic is_alloc;
        logic in_range;
        logic scan_none;
        logic hit;
        logic scan_end;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// File: rtl/bca_ctrl.sv
`default_nettype none

module bca_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    input  bca_pkg::t_sts  i_sts,
    output bca_pkg::t_cmd  o_cmd,
    output logic           o_in_ready
);

    bca_pkg::t_state r_state;
    bca_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bca_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bca_pkg::S_CLEAR: begin
                if (i_sts.clr_last) n_state = bca_pkg::S_IDLE;
            end
            bca_pkg::S_IDLE: begin
                if (i_in_valid) n_state = bca_pkg::S_READ;
            end
            bca_pkg::S_READ: begin
                if (i_sts.is_alloc) begin
                    n_state = bca_pkg::S_SCAN;
                end else if (i_sts.in_range) begin
                    n_state = bca_pkg::S_UPD;
                end else begin
                    n_state = bca_pkg::S_DONE;
                end
            end
            bca_pkg::S_UPD: begin
                n_state = bca_pkg::S_DONE;
            end
            bca_pkg::S_SCAN: begin
                if (i_sts.scan_none) begin
                    n_state = bca_pkg::S_DONE;
                end else if (i_sts.hit) begin
                    n_state = bca_pkg::S_COMMIT;
                end else if (i_sts.scan_end) begin
                    n_state = bca_pkg::S_DONE;
                end
            end
            bca_pkg::S_COMMIT: begin
                n_state = bca_pkg::S_DONE;
            end
            bca_pkg::S_DONE: begin
                if (i_sts.out_free) n_state = bca_pkg::S_IDLE;
            end
            default: begin
                n_state = bca_pkg::S_CLEAR;
            end
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            bca_pkg::S_CLEAR: begin
                o_cmd.clr = 1'b1;
            end
            bca_pkg::S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            bca_pkg::S_READ: begin
                o_cmd.res_range = !i_sts.is_alloc && !i_sts.in_range;
            end
            bca_pkg::S_UPD: begin
                o_cmd.upd = 1'b1;
            end
            bca_pkg::S_SCAN: begin
                o_cmd.scan     = 1'b1;
                o_cmd.res_full = i_sts.scan_none || (!i_sts.hit && i_sts.scan_end);
            end
            bca_pkg::S_COMMIT: begin
                o_cmd.commit = 1'b1;
            end
            bca_pkg::S_DONE: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/bca_dpath.sv
`default_nettype none

module bca_dpath (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  bca_pkg::t_cmd                    i_cmd,
    output bca_pkg::t_sts                    o_sts,
    input  wire                              i_cfg_we,
    input  wire  [bca_pkg::COUNT_W-1:0]      i_cfg_data,
    input  wire  [bca_pkg::OP_W-1:0]         i_op,
    input  wire  [bca_pkg::CLUSTER_W-1:0]    i_cluster,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic [bca_pkg::CLUSTER_W-1:0]    o_out_cluster,
    output logic                             o_out_wf,
    output logic [bca_pkg::ST_W-1:0]         o_out_st
);

    localparam int WORD_W  = bca_pkg::WORD_W;
    localparam int BIT_W   = bca_pkg::BIT_W;
    localparam int ADDR_W  = bca_pkg::ADDR_W;
    localparam int CNT_W   = bca_pkg::CNT_W;
    localparam int COUNT_W = bca_pkg::COUNT_W;
    localparam int CL_W    = bca_pkg::CLUSTER_W;

    // bitmap memory, set bit = free cluster
    logic [WORD_W-1:0] r_mem [bca_pkg::MAP_WORDS];
    logic [WORD_W-1:0] r_rd_data;

    // configuration and latched item
    logic [COUNT_W-1:0] r_count;
    bca_pkg::t_op       r_op;
    logic [CL_W-1:0]    r_cluster;
    logic               r_in_range;
    logic [CNT_W-1:0]   r_scan_n;
    logic [ADDR_W-1:0]  r_last_idx;
    logic [BIT_W-1:0]   r_lim_lo;

    // scan and clear control
    logic [ADDR_W-1:0]  r_clr_addr;
    logic [CNT_W-1:0]   r_issue;
    logic               r_pend;
    logic [ADDR_W-1:0]  r_pend_idx;

    // hit capture
    logic [WORD_W-1:0]  r_hit_word;
    logic [WORD_W-1:0]  r_hit_low;
    logic [ADDR_W-1:0]  r_hit_idx;

    // result and output word
    logic [CL_W-1:0]    r_res_cluster;
    logic               r_res_wf;
    bca_pkg::t_status   r_res_st;
    logic               r_out_valid;
    logic [CL_W-1:0]    r_out_cluster;
    logic               r_out_wf;
    bca_pkg::t_status   r_out_st;

    logic [COUNT_W-1:0] w_lim;
    logic [COUNT_W:0]   w_lim_sum;
    logic [CNT_W-1:0]   w_n_words;
    logic [ADDR_W-1:0]  w_cl_word;
    logic [ADDR_W-1:0]  w_rd_addr;
    logic               w_issue_ok;
    logic [WORD_W-1:0]  w_mask;
    logic [WORD_W-1:0]  w_masked;
    logic [WORD_W-1:0]  w_low;
    logic [BIT_W-1:0]   w_pos;
    logic [CL_W-1:0]    w_alloc_cl;
    logic [WORD_W-1:0]  w_bit;
    logic               w_wf;
    logic               w_we;
    logic [ADDR_W-1:0]  w_wr_addr;
    logic [WORD_W-1:0]  w_wr_data;
    logic               w_is_wr_op;

    // effective limit and word count of the scan
    always_comb begin
        w_lim      = (r_count > COUNT_W'(bca_pkg::CLAMP)) ? COUNT_W'(bca_pkg::CLAMP) : r_count;
        w_lim_sum  = {1'b0, w_lim} + (COUNT_W+1)'(WORD_W - 1);
        w_n_words  = CNT_W'(w_lim_sum >> BIT_W);
        w_cl_word  = ADDR_W'(r_cluster >> BIT_W);
        w_issue_ok = r_issue < r_scan_n;
        w_rd_addr  = i_cmd.scan ? r_issue[ADDR_W-1:0] : w_cl_word;
    end

    // search of the word that just came back
    always_comb begin
        if ((r_pend_idx == r_last_idx) && (r_lim_lo != '0)) begin
            w_mask = ~({WORD_W{1'b1}} << r_lim_lo);
        end else begin
            w_mask = {WORD_W{1'b1}};
        end
        w_masked = r_rd_data & w_mask;
        w_low    = w_masked & (~w_masked + WORD_W'(1));
    end

    // one-hot to bit position
    always_comb begin
        w_pos = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (r_hit_low[i]) w_pos = w_pos | BIT_W'(i);
        end
        w_alloc_cl = CL_W'({r_hit_idx, w_pos});
    end

    // single-cluster access
    always_comb begin
        w_bit      = WORD_W'(1) << r_cluster[BIT_W-1:0];
        w_wf       = r_rd_data[r_cluster[BIT_W-1:0]];
        w_is_wr_op = (r_op == bca_pkg::OP_FREE) || (r_op == bca_pkg::OP_MARK);
    end

    // write port select
    always_comb begin
        w_we      = 1'b0;
        w_wr_addr = r_clr_addr;
        w_wr_data = {WORD_W{1'b1}};
        if (i_cmd.clr) begin
            w_we      = 1'b1;
            w_wr_addr = r_clr_addr;
            // clusters zero and one start out used
            w_wr_data = (r_clr_addr == '0) ? ~WORD_W'(3) : {WORD_W{1'b1}};
        end else if (i_cmd.upd && w_is_wr_op) begin
            w_we      = 1'b1;
            w_wr_addr = w_cl_word;
            w_wr_data = (r_op == bca_pkg::OP_FREE) ? (r_rd_data | w_bit)
                                                   : (r_rd_data & ~w_bit);
        end else if (i_cmd.commit) begin
            w_we      = 1'b1;
            w_wr_addr = r_hit_idx;
            w_wr_data = r_hit_word & ~r_hit_low;
        end
    end

    // bitmap memory
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_wr_addr] <= w_wr_data;
        r_rd_data <= r_mem[w_rd_addr];
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_W'(bca_pkg::COUNT_RESET);
        end else if (i_cfg_we) begin
            r_count <= i_cfg_data;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_issue     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr) r_clr_addr <= r_clr_addr + ADDR_W'(1);
            if (i_cmd.accept) begin
                r_issue <= '0;
                r_pend  <= 1'b0;
            end else if (i_cmd.scan) begin
                r_pend <= w_issue_ok;
                if (w_issue_ok) r_issue <= r_issue + CNT_W'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item, scan and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op       <= bca_pkg::t_op'(i_op);
            r_cluster  <= i_cluster;
            r_in_range <= {1'b0, i_cluster} < w_lim;
            r_scan_n   <= w_n_words;
            r_last_idx <= ADDR_W'(w_n_words - CNT_W'(1));
            r_lim_lo   <= w_lim[BIT_W-1:0];
        end
        if (i_cmd.scan) r_pend_idx <= r_issue[ADDR_W-1:0];
        if (i_cmd.scan && r_pend && (w_masked != '0)) begin
            r_hit_word <= r_rd_data;
            r_hit_low  <= w_low;
            r_hit_idx  <= r_pend_idx;
        end
        if (i_cmd.res_range) begin
            r_res_cluster <= r_cluster;
            r_res_wf      <= 1'b0;
            r_res_st      <= bca_pkg::ST_RANGE;
        end else if (i_cmd.res_full) begin
            r_res_cluster <= '0;
            r_res_wf      <= 1'b0;
            r_res_st      <= bca_pkg::ST_FULL;
        end else if (i_cmd.upd) begin
            r_res_cluster <= r_cluster;
            r_res_wf      <= w_wf;
            r_res_st      <= bca_pkg::ST_OK;
        end else if (i_cmd.commit) begin
            r_res_cluster <= w_alloc_cl;
            r_res_wf      <= 1'b1;
            r_res_st      <= bca_pkg::ST_OK;
        end
        if (i_cmd.out_load) begin
            r_out_cluster <= r_res_cluster;
            r_out_wf      <= r_res_wf;
            r_out_st      <= r_res_st;
        end
    end

    // status to controller
    always_comb begin
        o_sts.clr_last  = r_clr_addr == ADDR_W'(bca_pkg::MAP_WORDS - 1);
        o_sts.is_alloc  = r_op == bca_pkg::OP_ALLOC;
        o_sts.in_range  = r_in_range;
        o_sts.scan_none = r_scan_n == '0;
        o_sts.hit       = r_pend && (w_masked != '0);
        o_sts.scan_end  = r_pend && (r_pend_idx == r_last_idx);
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_cluster = r_out_cluster;
    assign o_out_wf      = r_out_wf;
    assign o_out_st      = r_out_st;

endmodule

`default_nettype wire

// File: rtl/cluster_bitmap_allocator.sv
`default_nettype none

// channel  | dir | tdata (low bit up)                          | tuser
// s_axis   | in  | [13:0] cluster, [15:14] zero                | [1:0] opcode
// m_axis   | out | [13:0] result_cluster, [14] was_free, [15] 0 | [1:0] status
// cfg      | in  | i_cfg_data[14:0] cluster_count on i_cfg_we  | -
//
// query, free, mark: the result word follows the read and update states, only the read state when out of range;
// the next item can be taken in the same cycle that the result word shows up.
// allocate: the scan reads one bitmap word per cycle through the single read port, from word zero up to
// the word of the first free cluster, or all ceil(limit/64) words when none is free.
// after reset a clearing pass writes all 256 bitmap words with s_axis_tready low.
// a held m_axis word does not block taking an item; the item waits with its result until then.

module cluster_bitmap_allocator (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire  [15:0]                   s_axis_tdata,   // [13:0] cluster
    input  wire  [1:0]                    s_axis_tuser,   // [1:0] opcode
    output logic                          m_axis_tvalid,
    input  wire                           m_axis_tready,
    output logic [15:0]                   m_axis_tdata,   // [13:0] result_cluster, [14] was_free
    output logic [1:0]                    m_axis_tuser,   // [1:0] status
    input  wire                           i_cfg_we,
    input  wire  [bca_pkg::COUNT_W-1:0]   i_cfg_data
);

    bca_pkg::t_cmd                  w_cmd;
    bca_pkg::t_sts                  w_sts;
    logic [bca_pkg::CLUSTER_W-1:0]  w_out_cluster;
    logic                           w_out_wf;

    // sequencer
    bca_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_ready (s_axis_tready)
    );

    // bitmap, search and output word
    bca_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_op          (s_axis_tuser),
        .i_cluster     (s_axis_tdata[bca_pkg::CLUSTER_W-1:0]),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_out_cluster (w_out_cluster),
        .o_out_wf      (w_out_wf),
        .o_out_st      (m_axis_tuser)
    );

    assign m_axis_tdata = {1'b0, w_out_wf, w_out_cluster};

endmodule

`default_nettype wire

// File: rtl/bca_checker.sv
`default_nettype none

module bca_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          s_axis_tvalid,
    input wire                          s_axis_tready,
    input wire                          m_axis_tvalid,
    input wire                          m_axis_tready,
    input wire [15:0]                   m_axis_tdata,
    input wire [1:0]                    m_axis_tuser
);

    // reset empties the output word
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output word valid right after reset");

    // a held output word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled output word changed");

    // one item at a time: busy right after taking a word
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again the cycle after an accept");

    // failed operations report a used cluster
    a_fail_not_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != bca_pkg::ST_OK) |-> !m_axis_tdata[14])
        else $error("was_free set on a failed operation");

    // nothing free gives cluster zero
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == bca_pkg::ST_FULL) |-> (m_axis_tdata[13:0] == 14'd0))
        else $error("full status with a nonzero cluster");

endmodule

bind cluster_bitmap_allocator bca_checker u_bca_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
